// ----- rtl/qrv_pkg.sv -----
package qrv_pkg;

	localparam int CompWidth  = 16;
	localparam int ProdWidth  = 2 * CompWidth;
	localparam int MatWidth   = ProdWidth + 2;
	localparam int NormWidth  = ProdWidth + 1;
	localparam int MvWidth    = MatWidth + CompWidth;
	localparam int SumWidth   = MvWidth + 2;
	localparam int RemWidth   = SumWidth + 1;
	localparam int QuoBits    = CompWidth + 1;
	localparam int InBits     = 7 * CompWidth;
	localparam int OutBits    = 3 * CompWidth;
	localparam int UserBits   = 2;

	typedef logic signed [CompWidth-1:0] comp_t;
	typedef logic signed [ProdWidth-1:0] prod_t;
	typedef logic signed [MatWidth-1:0]  mat_t;
	typedef logic        [NormWidth-1:0] norm_t;
	typedef logic signed [MvWidth-1:0]   mv_t;
	typedef logic signed [SumWidth-1:0]  sum_t;
	typedef logic        [RemWidth-1:0]  rem_t;
	typedef logic        [QuoBits-1:0]   quo_t;

	typedef struct packed {
		logic zero_quat;
		logic saturated;
	} flags_t;

endpackage

// ----- rtl/quaternion_rotate_vector_unit.sv -----
// channel   direction  transaction contents
// s_axis    in         tdata: q_w q_x q_y q_z v_x v_y v_z, 16 bits each
// m_axis    out        tdata: r_x r_y r_z, 16 bits each; tuser: zero_quat saturated
//
// one vector per cycle while the skid register is empty; 4 arithmetic stages,
// 17 restoring divider stages and one output register
// the per-component division by the squared norm sets the depth: one quotient bit per stage
// arst_n clears all valid bits; data registers are not reset
// a skid register behind the output lets one result wait; the pipeline then holds
module quaternion_rotate_vector_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [qrv_pkg::InBits-1:0]    s_axis_tdata,   // q_w q_x q_y q_z v_x v_y v_z
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [qrv_pkg::OutBits-1:0]   m_axis_tdata,   // r_x r_y r_z
	output logic [qrv_pkg::UserBits-1:0]  m_axis_tuser    // zero_quat saturated
);
	import qrv_pkg::*;

	logic en;
	logic skid_q;
	logic [OutBits-1:0] skid_data_q;
	flags_t skid_flags_q;

	assign en = ~skid_q;
	assign s_axis_tready = ~skid_q;

	comp_t qw, qx, qy, qz;
	assign qw = s_axis_tdata[0*CompWidth +: CompWidth];
	assign qx = s_axis_tdata[1*CompWidth +: CompWidth];
	assign qy = s_axis_tdata[2*CompWidth +: CompWidth];
	assign qz = s_axis_tdata[3*CompWidth +: CompWidth];

	// stage 1: pairwise products
	logic  valid_s1;
	prod_t ww_s1, xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	comp_t v_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ww_s1 <= qw * qw;
			xx_s1 <= qx * qx;
			yy_s1 <= qy * qy;
			zz_s1 <= qz * qz;
			xy_s1 <= qx * qy;
			xz_s1 <= qx * qz;
			yz_s1 <= qy * qz;
			wx_s1 <= qw * qx;
			wy_s1 <= qw * qy;
			wz_s1 <= qw * qz;
			for (int i = 0; i < 3; i++) begin
				v_s1[i] <= s_axis_tdata[(4+i)*CompWidth +: CompWidth];
			end
		end
	end

	// stage 2: rotation matrix scaled by the squared norm
	logic  valid_s2;
	mat_t  m_s2 [9];
	norm_t norm_s2;
	comp_t v_s2 [3];
	mat_t  ww_e, xx_e, yy_e, zz_e, xy_e, xz_e, yz_e, wx_e, wy_e, wz_e;

	assign ww_e = MatWidth'(ww_s1);
	assign xx_e = MatWidth'(xx_s1);
	assign yy_e = MatWidth'(yy_s1);
	assign zz_e = MatWidth'(zz_s1);
	assign xy_e = MatWidth'(xy_s1);
	assign xz_e = MatWidth'(xz_s1);
	assign yz_e = MatWidth'(yz_s1);
	assign wx_e = MatWidth'(wx_s1);
	assign wy_e = MatWidth'(wy_s1);
	assign wz_e = MatWidth'(wz_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s2[0] <= ww_e + xx_e - yy_e - zz_e;
			m_s2[1] <= (xy_e - wz_e) <<< 1;
			m_s2[2] <= (xz_e + wy_e) <<< 1;
			m_s2[3] <= (xy_e + wz_e) <<< 1;
			m_s2[4] <= ww_e - xx_e + yy_e - zz_e;
			m_s2[5] <= (yz_e - wx_e) <<< 1;
			m_s2[6] <= (xz_e - wy_e) <<< 1;
			m_s2[7] <= (yz_e + wx_e) <<< 1;
			m_s2[8] <= ww_e - xx_e - yy_e + zz_e;
			norm_s2 <= NormWidth'(ww_e + xx_e + yy_e + zz_e);
			v_s2 <= v_s1;
		end
	end

	// stage 3: matrix times vector products
	logic  valid_s3;
	mv_t   p_s3 [9];
	norm_t norm_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++) begin
				p_s3[i] <= MvWidth'(m_s2[i]) * MvWidth'(v_s2[i % 3]);
			end
			norm_s3 <= norm_s2;
		end
	end

	// stage 4: row sums, magnitude plus half divisor for rounding
	logic  valid_s4;
	rem_t  num_s4 [3];
	logic  neg_s4 [3];
	norm_t norm_s4;
	sum_t  row [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			row[i] = SumWidth'(p_s3[3*i]) + SumWidth'(p_s3[3*i+1]) + SumWidth'(p_s3[3*i+2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s4[i] <= row[i][SumWidth-1];
				num_s4[i] <= (row[i][SumWidth-1] ? RemWidth'(-row[i]) : RemWidth'(row[i]))
					+ RemWidth'(norm_s3 >> 1);
			end
			norm_s4 <= norm_s3;
		end
	end

	// restoring divider, one quotient bit per stage, msb first
	logic  dv_valid_s [QuoBits+1];
	rem_t  dv_rem_s   [QuoBits+1][3];
	quo_t  dv_quo_s   [QuoBits+1][3];
	logic  dv_neg_s   [QuoBits+1][3];
	norm_t dv_den_s   [QuoBits+1];

	always_comb begin
		dv_valid_s[0] = valid_s4;
		dv_den_s[0]   = norm_s4;
		for (int i = 0; i < 3; i++) begin
			dv_rem_s[0][i] = num_s4[i];
			dv_quo_s[0][i] = '0;
			dv_neg_s[0][i] = neg_s4[i];
		end
	end

	for (genvar k = 0; k < QuoBits; k++) begin : g_div
		localparam int Bit = QuoBits - 1 - k;
		rem_t shifted;
		rem_t diff [3];
		logic take [3];

		assign shifted = RemWidth'(dv_den_s[k]) << Bit;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				take[i] = dv_rem_s[k][i] >= shifted;
				diff[i] = dv_rem_s[k][i] - shifted;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_valid_s[k+1] <= 1'b0;
			end else if (en) begin
				dv_valid_s[k+1] <= dv_valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_den_s[k+1] <= dv_den_s[k];
				for (int i = 0; i < 3; i++) begin
					dv_rem_s[k+1][i] <= take[i] ? diff[i] : dv_rem_s[k][i];
					dv_quo_s[k+1][i] <= dv_quo_s[k][i] | (take[i] ? quo_t'(1) << Bit : '0);
					dv_neg_s[k+1][i] <= dv_neg_s[k][i];
				end
			end
		end
	end

	// sign, saturation and zero norm
	logic               fin_valid;
	logic [OutBits-1:0] fin_data;
	flags_t             fin_flags;
	logic               any_sat;
	logic               is_zero;
	quo_t               qmag;
	logic               csat;

	always_comb begin
		fin_valid = dv_valid_s[QuoBits];
		is_zero   = dv_den_s[QuoBits] == '0;
		any_sat   = 1'b0;
		fin_data  = '0;
		for (int i = 0; i < 3; i++) begin
			qmag = dv_quo_s[QuoBits][i];
			if (dv_neg_s[QuoBits][i]) begin
				csat = qmag > quo_t'(1) << (CompWidth - 1);
				fin_data[i*CompWidth +: CompWidth] = csat ? {1'b1, {(CompWidth-1){1'b0}}}
					: CompWidth'(-qmag);
			end else begin
				csat = qmag > (quo_t'(1) << (CompWidth - 1)) - quo_t'(1);
				fin_data[i*CompWidth +: CompWidth] = csat ? {1'b0, {(CompWidth-1){1'b1}}}
					: CompWidth'(qmag);
			end
			any_sat = any_sat | csat;
		end
		if (is_zero) begin
			fin_data = '0;
		end
		fin_flags.zero_quat = is_zero;
		fin_flags.saturated = any_sat & ~is_zero;
	end

	// output register and skid
	logic               out_valid_q;
	logic [OutBits-1:0] out_data_q;
	flags_t             out_flags_q;
	logic               leave;

	assign leave = en & fin_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_q      <= 1'b0;
		end else if (m_axis_tready || !out_valid_q) begin
			if (skid_q) begin
				out_valid_q <= 1'b1;
				skid_q      <= 1'b0;
			end else begin
				out_valid_q <= leave;
			end
		end else if (leave) begin
			skid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_axis_tready || !out_valid_q) begin
			if (skid_q) begin
				out_data_q  <= skid_data_q;
				out_flags_q <= skid_flags_q;
			end else begin
				out_data_q  <= fin_data;
				out_flags_q <= fin_flags;
			end
		end else if (leave) begin
			skid_data_q  <= fin_data;
			skid_flags_q <= fin_flags;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = {out_flags_q.saturated, out_flags_q.zero_quat};

endmodule

// ----- sim/quaternion_rotate_vector_unit_tb.sv -----
`timescale 1ns / 100ps

module quaternion_rotate_vector_unit_tb;
	import qrv_pkg::*;

	typedef struct packed {
		logic signed [15:0] z;
		logic signed [15:0] y;
		logic signed [15:0] x;
	} rvec_t;

	typedef struct {
		rvec_t vec;
		logic  zero_quat;
		logic  saturated;
	} rot_result_t;

	localparam int DrainCycles = 40;
	localparam int WatchdogLimit = 20000;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [InBits-1:0]    s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [OutBits-1:0]   m_axis_tdata;
	logic [UserBits-1:0]  m_axis_tuser;

	rot_result_t rotated_q[$];
	int mismatches;
	int idle_cycles;
	int src_idle_pct;
	int snk_idle_pct;

	quaternion_rotate_vector_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic longint round_div(longint num, longint den);
		longint mag;
		longint quo;
		mag = (num < 0) ? -num : num;
		quo = (mag + den / 2) / den;
		return (num < 0) ? -quo : quo;
	endfunction

	function automatic rot_result_t rotate_vector(logic [InBits-1:0] item);
		longint q[4];
		longint v[3];
		longint t[4];
		longint r[3];
		longint norm;
		longint c;
		rot_result_t res;
		for (int i = 0; i < 4; i++) q[i] = longint'($signed(item[16*i +: 16]));
		for (int i = 0; i < 3; i++) v[i] = longint'($signed(item[16*(4+i) +: 16]));
		res.vec = '0;
		res.zero_quat = 1'b0;
		res.saturated = 1'b0;
		norm = q[0]*q[0] + q[1]*q[1] + q[2]*q[2] + q[3]*q[3];
		if (norm == 0) begin
			res.zero_quat = 1'b1;
			return res;
		end
		// t = q * (0, v)
		t[0] = -q[1]*v[0] - q[2]*v[1] - q[3]*v[2];
		t[1] =  q[0]*v[0] + q[2]*v[2] - q[3]*v[1];
		t[2] =  q[0]*v[1] - q[1]*v[2] + q[3]*v[0];
		t[3] =  q[0]*v[2] + q[1]*v[1] - q[2]*v[0];
		// r = t * conj(q), vector part
		r[0] = -t[0]*q[1] + t[1]*q[0] - t[2]*q[3] + t[3]*q[2];
		r[1] = -t[0]*q[2] + t[1]*q[3] + t[2]*q[0] - t[3]*q[1];
		r[2] = -t[0]*q[3] - t[1]*q[2] + t[2]*q[1] + t[3]*q[0];
		for (int i = 0; i < 3; i++) begin
			c = round_div(r[i], norm);
			if (c > 32767) begin
				c = 32767;
				res.saturated = 1'b1;
			end else if (c < -32768) begin
				c = -32768;
				res.saturated = 1'b1;
			end
			res.vec[16*i +: 16] = c[15:0];
		end
		return res;
	endfunction

	task automatic send_item(logic [InBits-1:0] item);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= item;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		rotated_q.push_back(rotate_vector(item));
	endtask

	function automatic logic [InBits-1:0] pack_item(int qw, int qx, int qy, int qz,
			int vx, int vy, int vz);
		logic [InBits-1:0] item;
		item = {vz[15:0], vy[15:0], vx[15:0], qz[15:0], qy[15:0], qx[15:0], qw[15:0]};
		return item;
	endfunction

	function automatic int rand_comp();
		case ($urandom_range(5))
			0: return 32767;
			1: return -32768;
			2: return $urandom_range(16384) - 8192;
			default: return int'($signed(16'($urandom)));
		endcase
	endfunction

	task automatic wait_results_drained();
		s_axis_tvalid <= 1'b0;
		while (rotated_q.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		send_item(pack_item(16384, 0, 0, 0, 1000, -2000, 3000));
		send_item(pack_item(0, 0, 0, 0, 32767, -32768, 5));
		send_item(pack_item(0, 0, 0, 0, 0, 0, 0));
		send_item(pack_item(11585, 0, 0, 11585, 32767, 0, 0));
		send_item(pack_item(0, 16384, 0, 0, 32767, 32767, -32768));
		send_item(pack_item(-32768, -32768, -32768, -32768, 32767, 32767, 32767));
		send_item(pack_item(32767, 32767, 32767, 32767, -32768, -32768, -32768));
		send_item(pack_item(16384, 16384, 0, 0, 32767, 32767, 32767));
		send_item(pack_item(1, 1, 0, 0, -32768, 32767, -32768));
		send_item(pack_item(0, 0, 0, 1, 1, 1, 1));
		send_item(pack_item(1, 0, 1, 0, 1, 0, 0));
		send_item(pack_item(0, 1, 1, 1, 1, 0, 0));
		send_item(pack_item(3, 0, 0, 0, 1, -1, 2));
		send_item(pack_item(12000, -9000, 4000, 7000, 30000, -30000, 30000));
		send_item(pack_item(-1, 0, 0, 0, -1, -1, -1));
	endtask

	task automatic test_random(int count);
		for (int n = 0; n < count; n++)
			send_item(pack_item(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
				rand_comp(), rand_comp(), rand_comp()));
	endtask

	task automatic test_back_to_back(int count);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_random(count);
		src_idle_pct = 28;
		snk_idle_pct = 28;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// checker
	always @(posedge clk) begin
		rot_result_t exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (rotated_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result tdata=%h tuser=%b", m_axis_tdata, m_axis_tuser);
			end else begin
				exp_r = rotated_q.pop_front();
				if (m_axis_tdata !== exp_r.vec || m_axis_tuser[0] !== exp_r.zero_quat
						|| m_axis_tuser[1] !== exp_r.saturated) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp r=%h zq=%b sat=%b got r=%h user=%b",
							exp_r.vec, exp_r.zero_quat, exp_r.saturated,
							m_axis_tdata, m_axis_tuser);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WatchdogLimit) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		src_idle_pct  = 28;
		snk_idle_pct  = 28;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(300);
		wait_results_drained();
		test_back_to_back(150);
		test_random(300);
		wait_results_drained();
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0 && rotated_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
